@@ hdl/one_wire_bus_master_macros.svh @@
// assertion macros shared by the bus master checkers
// expects clk and rst_n to be visible where a macro is used
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define OWBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/owbm_pkg.sv @@
// shared types, phase codes and timing constants of the 1-Wire bus master
// no dependencies
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int BYTE_W = 8;
  localparam int TICK_W = 10;
  localparam int PHASE_W = 4;
  localparam int BITS_W = 4;

  localparam logic [TICK_W-1:0] PRE_RESET_TICKS    = 10'd0;
  localparam logic [TICK_W-1:0] ZERO_RELEASE_TICKS = 10'd10;
  localparam logic [BITS_W-1:0] BITS_PER_BYTE      = 4'd8;

  // command codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_SHORT_LOW      = 3'd0;
  localparam logic [2:0] CFG_ONE_RELEASE    = 3'd1;
  localparam logic [2:0] CFG_ZERO_LOW       = 3'd2;
  localparam logic [2:0] CFG_READ_SAMPLE    = 3'd3;
  localparam logic [2:0] CFG_READ_RECOVER   = 3'd4;
  localparam logic [2:0] CFG_RESET_LOW      = 3'd5;
  localparam logic [2:0] CFG_PRESENCE_SMPL  = 3'd6;
  localparam logic [2:0] CFG_RESET_RECOVER  = 3'd7;

  // bus phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
  localparam logic [PHASE_W-1:0] PH_RST_PRE  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RST_WAIT = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RST_REC  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_WR_LOW   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WR_REL   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_RD_LOW   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RD_WAIT  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RD_REC   = 4'd9;

  typedef struct packed {
    logic [TICK_W-1:0] short_low_ticks;
    logic [TICK_W-1:0] one_release_ticks;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0] read_sample_ticks;
    logic [TICK_W-1:0] read_recover_ticks;
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] presence_sample_ticks;
    logic [TICK_W-1:0] reset_recover_ticks;
  } cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              presence_level;
    logic              rejected;
  } res_t;

endpackage

@@ hdl/owbm_cfg.sv @@
// timing register file of the 1-Wire bus master
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_addr,
  input  logic [9:0]        wr_data,
  output owbm_pkg::cfg_t    cfg
);
  import owbm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_addr)
        CFG_SHORT_LOW:     cfg_nxt.short_low_ticks       = wr_data;
        CFG_ONE_RELEASE:   cfg_nxt.one_release_ticks     = wr_data;
        CFG_ZERO_LOW:      cfg_nxt.zero_low_ticks        = wr_data;
        CFG_READ_SAMPLE:   cfg_nxt.read_sample_ticks     = wr_data;
        CFG_READ_RECOVER:  cfg_nxt.read_recover_ticks    = wr_data;
        CFG_RESET_LOW:     cfg_nxt.reset_low_ticks       = wr_data;
        CFG_PRESENCE_SMPL: cfg_nxt.presence_sample_ticks = wr_data;
        CFG_RESET_RECOVER: cfg_nxt.reset_recover_ticks   = wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_low_ticks       <= 10'd6;
      cfg_r.one_release_ticks     <= 10'd64;
      cfg_r.zero_low_ticks        <= 10'd60;
      cfg_r.read_sample_ticks     <= 10'd9;
      cfg_r.read_recover_ticks    <= 10'd55;
      cfg_r.reset_low_ticks       <= 10'd480;
      cfg_r.presence_sample_ticks <= 10'd70;
      cfg_r.reset_recover_ticks   <= 10'd410;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/owbm_seq.sv @@
// phase sequencer of the 1-Wire bus master: state registers and next-state logic
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [1:0]     func,
  input  logic [7:0]     data_byte,
  input  logic           line_level,
  input  owbm_pkg::cfg_t cfg,
  output owbm_pkg::res_t res
);
  import owbm_pkg::*;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BITS_W-1:0]  bits;
    logic [BYTE_W-1:0]  shift;
    logic [BYTE_W-1:0]  last_read;
  } walk_t;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BYTE_W-1:0]  last_read_r, last_read_nxt;
  logic               presence_r, presence_nxt;

  logic [TICK_W-1:0]  cnt_inc;
  logic [TICK_W-1:0]  cur_len;
  logic               expired;
  logic               cmd_start;
  logic               rejected;
  logic               engaged;
  walk_t              start_w;
  walk_t              leave_w;
  walk_t              settled_w;

  function automatic logic [TICK_W-1:0] wr_low_len(input logic b, input cfg_t c);
    return b ? c.short_low_ticks : c.zero_low_ticks;
  endfunction

  function automatic logic [TICK_W-1:0] wr_rel_len(input logic b, input cfg_t c);
    return b ? c.one_release_ticks : ZERO_RELEASE_TICKS;
  endfunction

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
  endfunction

  function automatic logic [TICK_W-1:0] phase_len(input logic [PHASE_W-1:0] p,
                                                  input logic b, input cfg_t c);
    logic [TICK_W-1:0] n;
    n = '0;
    unique case (p)
      PH_RST_PRE:  n = PRE_RESET_TICKS;
      PH_RST_LOW:  n = c.reset_low_ticks;
      PH_RST_WAIT: n = at_least_one(c.presence_sample_ticks);
      PH_RST_REC:  n = c.reset_recover_ticks;
      PH_WR_LOW:   n = wr_low_len(b, c);
      PH_WR_REL:   n = wr_rel_len(b, c);
      PH_RD_LOW:   n = c.short_low_ticks;
      PH_RD_WAIT:  n = at_least_one(c.read_sample_ticks);
      PH_RD_REC:   n = c.read_recover_ticks;
      default:     n = '0;
    endcase
    return n;
  endfunction

  // pass over zero-length phases; each step only moves forward
  function automatic walk_t settle(input walk_t w, input cfg_t c);
    walk_t             s;
    logic              skip_one;
    logic              skip_zero;
    logic              run;
    logic [BITS_W-1:0] n;
    s = w;
    skip_one  = (c.short_low_ticks == '0) && (c.one_release_ticks == '0);
    skip_zero = (c.zero_low_ticks == '0) && (ZERO_RELEASE_TICKS == '0);
    run = 1'b1;
    n = '0;
    if (s.phase == PH_RST_PRE && PRE_RESET_TICKS == '0) s.phase = PH_RST_LOW;
    if (s.phase == PH_RST_LOW && c.reset_low_ticks == '0) s.phase = PH_RST_WAIT;
    if (s.phase == PH_RST_REC && c.reset_recover_ticks == '0) s.phase = PH_IDLE;
    if (s.phase == PH_WR_REL && wr_rel_len(s.shift[0], c) == '0) begin
      s.shift = s.shift >> 1;
      s.bits  = s.bits - 4'd1;
      s.phase = (s.bits == '0) ? PH_IDLE : PH_WR_LOW;
    end
    if (s.phase == PH_WR_LOW) begin
      // run of bits whose low and release times are both zero
      for (int i = 0; i < BYTE_W; i++) begin
        if (run && (s.shift[i] ? skip_one : skip_zero)) begin
          n = n + 4'd1;
        end else begin
          run = 1'b0;
        end
      end
      if (n > s.bits) n = s.bits;
      s.shift = s.shift >> n;
      s.bits  = s.bits - n;
      if (s.bits == '0) begin
        s.phase = PH_IDLE;
      end else if (wr_low_len(s.shift[0], c) == '0) begin
        s.phase = PH_WR_REL;
      end
    end
    if (s.phase == PH_RD_REC && c.read_recover_ticks == '0) begin
      s.bits = s.bits - 4'd1;
      if (s.bits == '0) begin
        s.phase     = PH_IDLE;
        s.last_read = s.shift;
      end else begin
        s.phase = PH_RD_LOW;
      end
    end
    if (s.phase == PH_RD_LOW && c.short_low_ticks == '0) s.phase = PH_RD_WAIT;
    return s;
  endfunction

  assign cnt_inc = tick_r + 10'd1;
  assign cur_len = phase_len(phase_r, shift_r[0], cfg);
  assign expired = (cnt_inc >= cur_len);
  assign cmd_start = (func != FUNC_TICK) && (phase_r == PH_IDLE);

  always_comb begin
    start_w.bits      = BITS_PER_BYTE;
    start_w.last_read = last_read_r;
    start_w.shift     = '0;
    start_w.phase     = PH_RD_LOW;
    case (func)
      FUNC_RESET: start_w.phase = PH_RST_PRE;
      FUNC_WRITE: begin
        start_w.phase = PH_WR_LOW;
        start_w.shift = data_byte;
      end
      default: start_w.phase = PH_RD_LOW;
    endcase
  end

  // end of the current phase on an expiring tick
  always_comb begin
    leave_w.phase     = phase_r;
    leave_w.bits      = bits_r;
    leave_w.shift     = shift_r;
    leave_w.last_read = last_read_r;
    unique case (phase_r)
      PH_RST_PRE:  leave_w.phase = PH_RST_LOW;
      PH_RST_LOW:  leave_w.phase = PH_RST_WAIT;
      PH_RST_WAIT: leave_w.phase = PH_RST_REC;
      PH_RST_REC:  leave_w.phase = PH_IDLE;
      PH_WR_LOW:   leave_w.phase = PH_WR_REL;
      PH_WR_REL: begin
        leave_w.shift = shift_r >> 1;
        leave_w.bits  = bits_r - 4'd1;
        leave_w.phase = (leave_w.bits == '0) ? PH_IDLE : PH_WR_LOW;
      end
      PH_RD_LOW:   leave_w.phase = PH_RD_WAIT;
      PH_RD_WAIT: begin
        leave_w.shift = {line_level, shift_r[BYTE_W-1:1]};
        leave_w.phase = PH_RD_REC;
      end
      PH_RD_REC: begin
        leave_w.bits = bits_r - 4'd1;
        if (leave_w.bits == '0) begin
          leave_w.phase     = PH_IDLE;
          leave_w.last_read = shift_r;
        end else begin
          leave_w.phase = PH_RD_LOW;
        end
      end
      default:     leave_w.phase = PH_IDLE;
    endcase
  end

  assign settled_w = settle(cmd_start ? start_w : leave_w, cfg);

  always_comb begin
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    bits_nxt      = bits_r;
    shift_nxt     = shift_r;
    last_read_nxt = last_read_r;
    presence_nxt  = presence_r;
    rejected      = 1'b0;
    engaged       = 1'b0;
    if (step_en) begin
      if (func != FUNC_TICK) begin
        if (phase_r != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          engaged       = 1'b1;
          phase_nxt     = settled_w.phase;
          bits_nxt      = settled_w.bits;
          shift_nxt     = settled_w.shift;
          last_read_nxt = settled_w.last_read;
          tick_nxt      = '0;
        end
      end else if (phase_r != PH_IDLE) begin
        engaged = 1'b1;
        if (expired) begin
          if (phase_r == PH_RST_WAIT) presence_nxt = line_level;
          phase_nxt     = settled_w.phase;
          bits_nxt      = settled_w.bits;
          shift_nxt     = settled_w.shift;
          last_read_nxt = settled_w.last_read;
          tick_nxt      = '0;
        end else begin
          tick_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bits_r      <= '0;
      shift_r     <= '0;
      last_read_r <= '0;
      presence_r  <= 1'b1;
    end else begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bits_r      <= bits_nxt;
      shift_r     <= shift_nxt;
      last_read_r <= last_read_nxt;
      presence_r  <= presence_nxt;
    end
  end

  assign res.drive_low = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                         (phase_nxt == PH_RD_LOW);
  assign res.busy_res       = (phase_nxt != PH_IDLE);
  assign res.done_res       = engaged && (phase_nxt == PH_IDLE);
  assign res.read_byte      = last_read_nxt;
  assign res.presence_level = presence_nxt;
  assign res.rejected       = rejected;

endmodule

@@ hdl/one_wire_bus_master.sv @@
// One-wire bus master. Every input transaction (a one-microsecond tick carrying the sampled
// line level, or a reset, write-byte or read-byte command) is taken on its accepting edge:
// the phase sequencer updates its state on that edge and the result transaction is
// captured in the output register on the same edge, so a new transaction can be accepted
// every cycle while in_tready is high. in_tready drops only while a result waits in the
// output register and out_tready is low. Timing registers are written through the cfg port.
// depends on owbm_pkg, owbm_cfg and owbm_seq
`timescale 1ns / 1ps

module one_wire_bus_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [9:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], line_level[8], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // drive_low[0], busy_res[1], done_res[2], read_byte[10:3],
                                  // presence_level[11], rejected[12], zero pad
);
  import owbm_pkg::*;

  cfg_t        cfg;
  res_t        res;
  logic        in_accept;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r;

  assign cfg_ready = 1'b1;

  owbm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  owbm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .func       (in_tuser),
    .data_byte  (in_tdata[7:0]),
    .line_level (in_tdata[8]),
    .cfg        (cfg),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {3'b000, res.rejected, res.presence_level, res.read_byte,
                     res.done_res, res.busy_res, res.drive_low};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hdl/owbm_checker.sv @@
// port-level checks of the 1-Wire bus master, bound to the top level
// depends on one_wire_bus_master_macros.svh and one_wire_bus_master
`timescale 1ns / 1ps
`include "one_wire_bus_master_macros.svh"

module owbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // stalled result transaction holds
  `OWBM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // no new transaction while a result is stalled
  `OWBM_ASSERT_SAME(a_in_block, out_tvalid && !out_tready, !in_tready, "input taken over a stalled result")

  // line only driven while an operation runs
  `OWBM_ASSERT_SAME(a_drive_busy, out_tvalid && out_tdata[0], out_tdata[1], "drive low while idle")

  // finished operation is never still busy
  `OWBM_ASSERT_SAME(a_done_idle, out_tvalid && out_tdata[2], !out_tdata[1], "done while busy")

  // refused command leaves the running operation alone
  `OWBM_ASSERT_SAME(a_reject_busy, out_tvalid && out_tdata[12], out_tdata[1] && !out_tdata[2], "reject without busy")

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
